// ===== design/dct_pkg.sv =====
// Shared types, constants and the segment table of the duty-cycle thermometer display.
package dct_pkg;

	// Default width of the run counter and of the captured high and low times.
	localparam int COUNT_WIDTH_DEF = 16;

	// Display geometry.
	localparam int NUM_DIGITS  = 4;
	localparam int DIGIT_IDX_W = 3;
	localparam int CODE_W      = 4;
	localparam int SEG_W       = 8;
	localparam int EN_W        = NUM_DIGITS;
	localparam int DP_POS      = 2;

	localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
	localparam logic [CODE_W-1:0] CODE_BLANK = 4'd11;
	localparam logic [SEG_W-1:0]  DP_CLEAR_MASK = 8'h7F;
	localparam logic [EN_W-1:0]   EN_ALL_OFF = 4'hF;

	// Temperature arithmetic.
	localparam int TEMP_W     = 12;
	localparam int DUTY_FRAC  = 16;
	localparam int DUTY_W     = DUTY_FRAC + 1;
	localparam int PROD_W     = 35;
	localparam int PROD_SHIFT = 20;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 12'h7FF;
	localparam logic [TEMP_W-1:0] TEMP_MIN = 12'h800;

	// Configuration port.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_OFFSET = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 4'd1;
	localparam logic [CFG_DATA_W-1:0]  OFFSET_RESET    = 16'd20972;
	localparam logic [CFG_DATA_W-1:0]  GAIN_RESET      = 16'd34043;

	// Depth of the queue between the capture front and the compute back.
	localparam int QUEUE_DEPTH = 2;

	typedef logic [CODE_W-1:0] code_t;

	// Per-request control flags handed from the front to the back.
	typedef struct packed {
		logic compute;
		logic refresh;
	} job_ctl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_SAT,
		BK_MOD,
		BK_HUND,
		BK_TENS,
		BK_SHOW
	} bk_state_t;

	// Active-low common-anode patterns: digits 0 to 9, minus, blank.
	function automatic logic [SEG_W-1:0] seg_lookup(input code_t code);
		logic [SEG_W-1:0] seg;
		case (code)
			4'd0:    seg = 8'd192;
			4'd1:    seg = 8'd249;
			4'd2:    seg = 8'd164;
			4'd3:    seg = 8'd176;
			4'd4:    seg = 8'd153;
			4'd5:    seg = 8'd146;
			4'd6:    seg = 8'd130;
			4'd7:    seg = 8'd248;
			4'd8:    seg = 8'd128;
			4'd9:    seg = 8'd144;
			4'd10:   seg = 8'd191;
			default: seg = 8'd255;
		endcase
		return seg;
	endfunction

endpackage

// ===== design/dct_channels.sv =====
// Valid/ready channel interfaces for samples, display results and configuration writes.
interface dct_in_if;
	import dct_pkg::*;
	logic valid;
	logic ready;
	logic sensor_level;
	logic refresh_tick;
	modport source(output valid, output sensor_level, output refresh_tick, input ready);
	modport sink(input valid, input sensor_level, input refresh_tick, output ready);
endinterface

interface dct_out_if;
	import dct_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [SEG_W-1:0]         segment_pattern;
	logic [EN_W-1:0]          digit_enables;
	logic signed [TEMP_W-1:0] temperature_tenths;
	modport source(output valid, output segment_pattern, output digit_enables,
		output temperature_tenths, input ready);
	modport sink(input valid, input segment_pattern, input digit_enables,
		input temperature_tenths, output ready);
endinterface

interface dct_cfg_if;
	import dct_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/dct_front.sv =====
// Capture front: edge detection, run counting and high/low time capture per sample.
module dct_front #(
	parameter int COUNT_WIDTH = dct_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	dct_in_if.sink                 sample,
	output logic                   job_valid,
	input  logic                   job_ready,
	output dct_pkg::job_ctl_t      job_ctl,
	output logic [COUNT_WIDTH-1:0] job_high,
	output logic [COUNT_WIDTH-1:0] job_low
);
	import dct_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic                   prev_q;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [COUNT_WIDTH-1:0] high_q, high_n;
	logic [COUNT_WIDTH-1:0] low_q, low_n;
	logic [1:0]             tv_q, tv_n;
	logic                   change;
	logic                   accept;

	assign sample.ready = job_ready;
	assign job_valid    = sample.valid;
	assign accept       = sample.valid && job_ready;
	assign change       = sample.sensor_level != prev_q;

	always_comb begin
		high_n = high_q;
		low_n  = low_q;
		tv_n   = tv_q;
		if (!change) begin
			cnt_n = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
		end else begin
			cnt_n = COUNT_WIDTH'(1);
			// A falling change closes a high run, a rising one a low run.
			if (prev_q) begin
				high_n   = cnt_q;
				tv_n[0]  = 1'b1;
			end else begin
				low_n    = cnt_q;
				tv_n[1]  = 1'b1;
			end
		end
	end

	assign job_ctl.compute = change && (&tv_n);
	assign job_ctl.refresh = sample.refresh_tick;
	assign job_high        = high_n;
	assign job_low         = low_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			cnt_q  <= '0;
			high_q <= '0;
			low_q  <= '0;
			tv_q   <= 2'b00;
		end else if (accept) begin
			prev_q <= sample.sensor_level;
			cnt_q  <= cnt_n;
			high_q <= high_n;
			low_q  <= low_n;
			tv_q   <= tv_n;
		end
	end

endmodule

// ===== design/dct_queue.sv =====
// Short FIFO that decouples the capture front from the compute back.
module dct_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = dct_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import dct_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/dct_back.sv =====
// Compute back: duty division, temperature scaling, digit conversion and display multiplex.
module dct_back #(
	parameter int COUNT_WIDTH = dct_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	dct_cfg_if.sink                cfg,
	input  logic                   job_valid,
	output logic                   job_ready,
	input  dct_pkg::job_ctl_t      job_ctl,
	input  logic [COUNT_WIDTH-1:0] job_high,
	input  logic [COUNT_WIDTH-1:0] job_low,
	dct_out_if.source              result
);
	import dct_pkg::*;

	localparam int STEP_W    = $clog2(DUTY_FRAC);
	localparam int SHIFTED_W = PROD_W - PROD_SHIFT;

	bk_state_t state_q, state_n;

	logic [CFG_DATA_W-1:0]  offset_q, gain_q;
	job_ctl_t               ctl_q;
	logic [COUNT_WIDTH:0]   period, period_q;
	logic [COUNT_WIDTH:0]   rem_q;
	logic [COUNT_WIDTH+1:0] rem2, rem_diff;
	logic                   rem_ge;
	logic [DUTY_W-1:0]      quo_q;
	logic [STEP_W-1:0]      step_q;
	logic                   div_last;
	logic                   first_bit;

	logic signed [DUTY_W:0]   diff_s;
	logic signed [DUTY_W-1:0] gain_s;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        prod_mag;
	logic [SHIFTED_W-1:0]     shifted;
	logic [TEMP_W-1:0]        temp_sat;
	logic [TEMP_W-1:0]        temp_q;
	logic [TEMP_W-1:0]        tmag;
	logic [9:0]               mod_n, mod_q;
	logic [3:0]               hund_n, tens_n;
	logic [6:0]               rest_q;

	code_t sign_q, hund_q, tens_q, unit_q;
	code_t codes_q [NUM_DIGITS];
	code_t cur_codes [NUM_DIGITS];

	logic [DIGIT_IDX_W-1:0] idx_q, idx_n;
	logic [1:0]             pos;
	logic                   snap;
	logic [SEG_W-1:0]       seg_q, seg_n;
	logic [EN_W-1:0]        en_q, en_n;
	logic [TEMP_W-1:0]      out_temp_q;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   show, show_refresh;
	logic                   pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DUTY_OFFSET: offset_q <= cfg.data;
				REG_GAIN:        gain_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || result.ready;
	assign period   = {1'b0, job_high} + {1'b0, job_low};
	assign pop      = job_valid && job_ready;

	// Sequencer for one request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		job_ready = 1'b0;
		show      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_ready = job_ctl.compute || out_free;
				if (job_valid && job_ready) begin
					if (job_ctl.compute) begin
						state_n = (period == '0) ? BK_MUL : BK_DIV;
					end else begin
						show = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_n = BK_MUL;
				end
			end
			BK_MUL:  state_n = BK_SAT;
			BK_SAT:  state_n = BK_MOD;
			BK_MOD:  state_n = BK_HUND;
			BK_HUND: state_n = BK_TENS;
			BK_TENS: state_n = BK_SHOW;
			BK_SHOW: begin
				if (out_free) begin
					show    = 1'b1;
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	assign show_refresh = (state_q == BK_SHOW) ? ctl_q.refresh : job_ctl.refresh;

	// Restoring division, one quotient bit per cycle.
	assign first_bit = ({1'b0, job_high} == period);
	assign rem2      = {rem_q, 1'b0};
	assign rem_diff  = rem2 - {1'b0, period_q};
	assign rem_ge    = rem2 >= {1'b0, period_q};
	assign div_last  = step_q == STEP_W'(DUTY_FRAC - 1);

	// Scaling and saturation.
	assign diff_s   = $signed({1'b0, quo_q}) - $signed({2'b00, offset_q});
	assign gain_s   = $signed({1'b0, gain_q});
	assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign shifted  = prod_mag[PROD_W-1:PROD_SHIFT];

	always_comb begin
		if (!prod_q[PROD_W-1]) begin
			temp_sat = (shifted > SHIFTED_W'(TEMP_MAX)) ? TEMP_MAX : shifted[TEMP_W-1:0];
		end else begin
			temp_sat = (shifted >= SHIFTED_W'(TEMP_MIN)) ? TEMP_MIN
				: TEMP_W'(-shifted[TEMP_W-1:0]);
		end
	end

	// Decimal digits of the magnitude modulo 1000.
	assign tmag = temp_q[TEMP_W-1] ? TEMP_W'(~temp_q + TEMP_W'(1)) : temp_q;

	always_comb begin
		if (tmag >= TEMP_W'(2000)) begin
			mod_n = 10'(tmag - TEMP_W'(2000));
		end else if (tmag >= TEMP_W'(1000)) begin
			mod_n = 10'(tmag - TEMP_W'(1000));
		end else begin
			mod_n = tmag[9:0];
		end
	end

	always_comb begin
		hund_n = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			hund_n = hund_n + 4'(mod_q >= 10'(100 * k));
		end
	end

	always_comb begin
		tens_n = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			tens_n = tens_n + 4'(rest_q >= 7'(10 * k));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop && job_ctl.compute) begin
					ctl_q    <= job_ctl;
					period_q <= period;
					step_q   <= '0;
					if (period == '0) begin
						quo_q <= '0;
					end else begin
						quo_q <= {first_bit, {DUTY_FRAC{1'b0}}};
						rem_q <= first_bit ? '0 : {1'b0, job_high};
					end
				end
			end
			BK_DIV: begin
				rem_q  <= rem_ge ? rem_diff[COUNT_WIDTH:0] : rem2[COUNT_WIDTH:0];
				quo_q  <= {quo_q[DUTY_W-1], quo_q[DUTY_W-3:0], rem_ge};
				step_q <= step_q + STEP_W'(1);
			end
			BK_MUL:  prod_q <= diff_s * gain_s;
			BK_MOD:  mod_q  <= mod_n;
			BK_HUND: rest_q <= 7'(mod_q - 10'(hund_n) * 10'd100);
			default: ;
		endcase
		if (show) begin
			out_temp_q <= temp_q;
		end
	end

	// Temperature and its digit set; both are visible state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			sign_q <= CODE_BLANK;
			hund_q <= '0;
			tens_q <= '0;
			unit_q <= '0;
		end else begin
			case (state_q)
				BK_SAT: temp_q <= temp_sat;
				BK_MOD: sign_q <= temp_q[TEMP_W-1] ? CODE_MINUS : CODE_BLANK;
				BK_HUND: hund_q <= hund_n;
				BK_TENS: begin
					tens_q <= tens_n;
					unit_q <= 4'(rest_q - 7'(tens_n) * 7'd10);
				end
				default: ;
			endcase
		end
	end

	// Display multiplex step.
	assign idx_n = (idx_q >= DIGIT_IDX_W'(NUM_DIGITS)) ? DIGIT_IDX_W'(1)
		: idx_q + DIGIT_IDX_W'(1);
	assign snap  = idx_n == DIGIT_IDX_W'(1);
	assign pos   = 2'(idx_n - DIGIT_IDX_W'(1));

	always_comb begin
		if (snap) begin
			cur_codes[0] = sign_q;
			cur_codes[1] = hund_q;
			cur_codes[2] = tens_q;
			cur_codes[3] = unit_q;
		end else begin
			cur_codes = codes_q;
		end
		seg_n = seg_lookup(cur_codes[pos]);
		if (pos == 2'(DP_POS)) begin
			seg_n = seg_n & DP_CLEAR_MASK;
		end
		en_n = EN_ALL_OFF ^ (EN_W'(1) << (2'(NUM_DIGITS - 1) - pos));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			codes_q[0]  <= CODE_BLANK;
			codes_q[1]  <= '0;
			codes_q[2]  <= '0;
			codes_q[3]  <= '0;
			seg_q       <= '0;
			en_q        <= EN_ALL_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (show) begin
				out_valid_q <= 1'b1;
				if (show_refresh) begin
					idx_q <= idx_n;
					seg_q <= seg_n;
					en_q  <= en_n;
					if (snap) begin
						codes_q <= cur_codes;
					end
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid              = out_valid_q;
	assign result.segment_pattern    = seg_q;
	assign result.digit_enables      = en_q;
	assign result.temperature_tenths = $signed(out_temp_q);

endmodule

// ===== design/duty_cycle_thermometer_display.sv =====
// Top level of the duty-cycle thermometer with a four-digit multiplexed display.
//
// Usage: the sample channel takes one request per capture tick, carrying the sampled
// sensor level and a refresh strobe. Every accepted sample yields exactly one request
// on the result channel: the active-low segment pattern, the active-low digit enables
// and the latest temperature in tenths of a degree, in sample order.
// The cfg channel writes the duty offset (index 0) and the gain (index 1); it is always
// ready, and writes are meant to happen while no sample is in flight.
// A sample that starts no temperature update passes through the queue entry and the
// result register, and such samples stream at one per cycle while the receiver does
// not stall. A sample that completes a high or low time, once both a high and a low
// time have been captured, starts a temperature update: a bit-serial duty division
// (skipped when the period is zero), a multiply, saturation and three digit-conversion
// steps. The back takes no other sample while an update runs.
// Reset clears the measurement, stores a zero reading with all digits dark and loads the default
// offset and gain. When the receiver stalls, the result is held and a two-entry queue
// keeps taking samples; once it fills, sample.ready drops until results drain.
module duty_cycle_thermometer_display #(
	parameter int COUNT_WIDTH = dct_pkg::COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dct_in_if.sink    sample,
	dct_out_if.source result,
	dct_cfg_if.sink   cfg
);
	import dct_pkg::*;

	localparam int CTL_W = $bits(job_ctl_t);
	localparam int JOB_W = CTL_W + 2 * COUNT_WIDTH;

	// Front to queue.
	logic                   f_valid, f_ready;
	job_ctl_t               f_ctl;
	logic [COUNT_WIDTH-1:0] f_high, f_low;

	// Queue to back.
	logic                   b_valid, b_ready;
	logic [JOB_W-1:0]       b_data;
	job_ctl_t               b_ctl;
	logic [COUNT_WIDTH-1:0] b_high, b_low;

	// The front tracks the sensor runs and tags each sample with whether it
	// produced a fresh pair of times.
	dct_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.job_valid(f_valid),
		.job_ready(f_ready),
		.job_ctl  (f_ctl),
		.job_high (f_high),
		.job_low  (f_low)
	);

	// The queue lets the front keep sampling while the back is busy dividing
	// or the receiver is stalled.
	dct_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data ({f_ctl, f_high, f_low}),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	assign b_ctl  = job_ctl_t'(b_data[JOB_W-1 -: CTL_W]);
	assign b_high = b_data[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
	assign b_low  = b_data[COUNT_WIDTH-1:0];

	// The back computes the temperature when asked, steps the display and
	// holds the result register.
	dct_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.job_ctl  (b_ctl),
		.job_high (b_high),
		.job_low  (b_low),
		.result   (result)
	);

endmodule

// ===== design/dct_checker.sv =====
// Port-level assertions for the duty-cycle thermometer display, bound to the top level.
module dct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [dct_pkg::SEG_W-1:0]        segment_pattern,
	input logic [dct_pkg::EN_W-1:0]         digit_enables,
	input logic signed [dct_pkg::TEMP_W-1:0] temperature_tenths
);
	import dct_pkg::*;

	// Digit one sits on bit 3, so the third digit (tens) is enabled by a low bit 1.
	localparam logic [EN_W-1:0] EN_DIGIT_THREE = 4'b1101;

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_pattern)
			&& $stable(digit_enables) && $stable(temperature_tenths))
		else $error("result changed while stalled");

	// At most one digit is driven at a time.
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(~digit_enables) <= 1)
		else $error("more than one digit enabled");

	// Before the first refresh, all segments carry their reset pattern.
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_enables == EN_ALL_OFF |-> segment_pattern == '0)
		else $error("segments driven with no digit shown");

	// The decimal point is lit on the tens digit and nowhere else.
	a_dp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_enables != EN_ALL_OFF
			|-> (segment_pattern[SEG_W-1] == 1'b0) == (digit_enables == EN_DIGIT_THREE))
		else $error("decimal point on the wrong digit");

endmodule

bind duty_cycle_thermometer_display dct_checker u_dct_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.segment_pattern   (result.segment_pattern),
	.digit_enables     (result.digit_enables),
	.temperature_tenths(result.temperature_tenths)
);
